// ===== hdl/cpt_pkg.sv =====
// shared types and constants of the closest point on triangle block
package cpt_pkg;

   localparam int COORD_W     = 24;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int DOT_W       = 52;
   localparam int HALF_W      = DOT_W / 2;
   localparam int PROD_W      = 2 * DOT_W;
   localparam int NUM_W       = 108;
   localparam int LIMIT_W     = 52;
   localparam int WEIGHT_W    = 17;
   localparam int DIV_STEPS   = 32;
   localparam int FRAC_W      = DIV_STEPS + 1;
   localparam int DIV_LAT     = DIV_STEPS + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [NUM_W-1:0]   num_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      REG_EARLY   = 3'd0,
      REG_VERT_A  = 3'd1,
      REG_VERT_B  = 3'd2,
      REG_EDGE_AB = 3'd3,
      REG_VERT_C  = 3'd4,
      REG_EDGE_AC = 3'd5,
      REG_EDGE_BC = 3'd6,
      REG_FACE    = 3'd7
   } region_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      diff_type x;
      diff_type y;
      diff_type z;
   } dvec_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type corner_a_x;
      coord_type corner_a_y;
      coord_type corner_a_z;
      coord_type corner_b_x;
      coord_type corner_b_y;
      coord_type corner_b_z;
      coord_type corner_c_x;
      coord_type corner_c_y;
      coord_type corner_c_z;
   } req_type;

   typedef struct packed {
      coord_type            nearest_x;
      coord_type            nearest_y;
      coord_type            nearest_z;
      logic [WEIGHT_W-1:0]  weight_a;
      logic [WEIGHT_W-1:0]  weight_b;
      logic [WEIGHT_W-1:0]  weight_c;
      region_type           region;
   } rsp_type;

   // classified work handed from the front to the back
   typedef struct packed {
      region_type region;
      vec_type    base;
      dvec_type   e1;
      dvec_type   e2;
      num_type    num0;
      num_type    num1;
      num_type    den;
   } task_type;

endpackage

// ===== hdl/cpt_div.sv =====
// pipelined restoring divider giving a saturated fraction num/den with 32 fraction bits
module cpt_div (
   input  logic                          clock,
   input  logic                          adv,
   input  cpt_pkg::num_type              num,
   input  cpt_pkg::num_type              den,
   output logic [cpt_pkg::FRAC_W-1:0]    frac
);

   localparam int REM_W = cpt_pkg::NUM_W + 1;
   localparam int STEPS = cpt_pkg::DIV_STEPS;

   typedef struct packed {
      logic             zero;
      logic             one;
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] dvs;
      logic [STEPS-1:0] quo;
   } step_type;

   step_type step_ff [STEPS+1];
   step_type step_in [STEPS+1];
   logic [REM_W-1:0] shift_w [STEPS+1];
   logic [cpt_pkg::FRAC_W-1:0] frac_ff, frac_in;

   always_comb begin
      step_in[0].zero = num[cpt_pkg::NUM_W-1] || (num == '0) ||
                        den[cpt_pkg::NUM_W-1] || (den == '0);
      step_in[0].one  = (num >= den);
      step_in[0].rem  = {1'b0, num};
      step_in[0].dvs  = {1'b0, den};
      step_in[0].quo  = '0;
      shift_w[0]      = '0;
      for (int k = 1; k <= STEPS; k++) begin
         shift_w[k]      = {step_ff[k-1].rem[REM_W-2:0], 1'b0};
         step_in[k].zero = step_ff[k-1].zero;
         step_in[k].one  = step_ff[k-1].one;
         step_in[k].dvs  = step_ff[k-1].dvs;
         if (shift_w[k] >= step_ff[k-1].dvs) begin
            step_in[k].rem = shift_w[k] - step_ff[k-1].dvs;
            step_in[k].quo = {step_ff[k-1].quo[STEPS-2:0], 1'b1};
         end else begin
            step_in[k].rem = shift_w[k];
            step_in[k].quo = {step_ff[k-1].quo[STEPS-2:0], 1'b0};
         end
      end
   end

   // saturate to zero or one, else round half up on the final remainder
   always_comb begin
      if (step_ff[STEPS].zero) begin
         frac_in = '0;
      end else if (step_ff[STEPS].one) begin
         frac_in = {1'b1, {STEPS{1'b0}}};
      end else if ({step_ff[STEPS].rem[REM_W-2:0], 1'b0} >= step_ff[STEPS].dvs) begin
         frac_in = {1'b0, step_ff[STEPS].quo} + cpt_pkg::FRAC_W'(1);
      end else begin
         frac_in = {1'b0, step_ff[STEPS].quo};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= STEPS; k++) begin
            step_ff[k] <= step_in[k];
         end
         frac_ff <= frac_in;
      end
   end

   assign frac = frac_ff;

endmodule

// ===== hdl/cpt_front.sv =====
// front: differences, dot products, early exit and region classification
module cpt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cpt_pkg::req_type              req_data,
   input  logic [cpt_pkg::LIMIT_W-1:0]   limit,
   input  logic                          full,
   output logic                          push,
   output cpt_pkg::task_type             push_data
);

   localparam int STAGES = 7;
   localparam int PP_W   = 2 * cpt_pkg::DIFF_W;
   localparam int E_W    = cpt_pkg::DOT_W + 2;
   localparam int HW     = cpt_pkg::HALF_W;
   localparam int DW     = cpt_pkg::DOT_W;
   localparam int NW     = cpt_pkg::NUM_W;

   typedef struct packed {
      logic signed [PP_W-1:0] x;
      logic signed [PP_W-1:0] y;
      logic signed [PP_W-1:0] z;
   } trip_type;

   typedef struct packed {
      logic signed [2*HW-1:0] hh;
      logic signed [2*HW:0]   hl;
      logic signed [2*HW:0]   lh;
      logic [2*HW-1:0]        ll;
   } part_type;

   typedef struct packed {
      cpt_pkg::vec_type  a;
      cpt_pkg::vec_type  b;
      cpt_pkg::vec_type  c;
      cpt_pkg::dvec_type ab;
      cpt_pkg::dvec_type ac;
      cpt_pkg::dvec_type cb;
   } geom_type;

   function automatic cpt_pkg::dvec_type dsub(cpt_pkg::vec_type p, cpt_pkg::vec_type q);
      cpt_pkg::dvec_type r;
      r.x = cpt_pkg::DIFF_W'(p.x) - cpt_pkg::DIFF_W'(q.x);
      r.y = cpt_pkg::DIFF_W'(p.y) - cpt_pkg::DIFF_W'(q.y);
      r.z = cpt_pkg::DIFF_W'(p.z) - cpt_pkg::DIFF_W'(q.z);
      return r;
   endfunction

   function automatic part_type split_mul(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
      part_type r;
      r.hh = $signed(x[DW-1:HW]) * $signed(y[DW-1:HW]);
      r.hl = $signed(x[DW-1:HW]) * $signed({1'b0, y[HW-1:0]});
      r.lh = $signed({1'b0, x[HW-1:0]}) * $signed(y[DW-1:HW]);
      r.ll = x[HW-1:0] * y[HW-1:0];
      return r;
   endfunction

   function automatic logic signed [cpt_pkg::PROD_W-1:0] join_mul(part_type p);
      return (cpt_pkg::PROD_W'(p.hh) <<< (2*HW)) + (cpt_pkg::PROD_W'(p.hl) <<< HW) +
             (cpt_pkg::PROD_W'(p.lh) <<< HW) + cpt_pkg::PROD_W'(p.ll);
   endfunction

   function automatic logic nonpos(cpt_pkg::num_type v);
      return v[NW-1] || (v == '0);
   endfunction

   logic adv;
   logic [STAGES-1:0] vld_ff;

   cpt_pkg::vec_type  a1_ff, b1_ff, c1_ff, p1_w;
   cpt_pkg::dvec_type ap1_ff, ab1_ff, ac1_ff, bp1_ff, cp1_ff, cb1_ff;
   cpt_pkg::vec_type  a1_in, b1_in, c1_in;

   geom_type geom2_ff, geom3_ff, geom4_ff, geom5_ff, geom6_ff;
   cpt_pkg::dvec_type opa [9];
   cpt_pkg::dvec_type opb [9];
   trip_type prod2_ff [9];
   trip_type prod2_in [9];

   logic signed [DW-1:0] dot3_ff [9];
   logic signed [DW-1:0] dot3_in [9];

   logic signed [E_W-1:0] e_w;
   logic early4_ff, early4_in, early5_ff, early6_ff;
   logic signed [DW-1:0] d4_ff [6];
   logic signed [DW-1:0] d5_ff [6];
   logic signed [DW-1:0] d6_ff [6];
   part_type part4_ff [6];
   part_type part4_in [6];

   logic signed [cpt_pkg::PROD_W-1:0] prod5_ff [6];
   logic signed [cpt_pkg::PROD_W-1:0] prod5_in [6];

   cpt_pkg::num_type va6_ff, vb6_ff, vc6_ff, va6_in, vb6_in, vc6_in;
   cpt_pkg::num_type n1, n2, n3, n4, n5, n6, d43, d56, den_f;
   cpt_pkg::task_type task7_ff, task7_in;

   assign adv       = !full;
   assign req_stall = full;
   assign push      = vld_ff[STAGES-1] && adv;
   assign push_data = task7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   // stage 1: edge and point vectors
   always_comb begin
      p1_w.x = req_data.point_x;
      p1_w.y = req_data.point_y;
      p1_w.z = req_data.point_z;
      a1_in.x = req_data.corner_a_x;
      a1_in.y = req_data.corner_a_y;
      a1_in.z = req_data.corner_a_z;
      b1_in.x = req_data.corner_b_x;
      b1_in.y = req_data.corner_b_y;
      b1_in.z = req_data.corner_b_z;
      c1_in.x = req_data.corner_c_x;
      c1_in.y = req_data.corner_c_y;
      c1_in.z = req_data.corner_c_z;
   end

   // stage 2: products of the nine dot products
   always_comb begin
      opa[0] = ap1_ff; opb[0] = ap1_ff;
      opa[1] = ab1_ff; opb[1] = ab1_ff;
      opa[2] = ac1_ff; opb[2] = ac1_ff;
      opa[3] = ab1_ff; opb[3] = ap1_ff;
      opa[4] = ac1_ff; opb[4] = ap1_ff;
      opa[5] = ab1_ff; opb[5] = bp1_ff;
      opa[6] = ac1_ff; opb[6] = bp1_ff;
      opa[7] = ab1_ff; opb[7] = cp1_ff;
      opa[8] = ac1_ff; opb[8] = cp1_ff;
      for (int i = 0; i < 9; i++) begin
         prod2_in[i].x = opa[i].x * opb[i].x;
         prod2_in[i].y = opa[i].y * opb[i].y;
         prod2_in[i].z = opa[i].z * opb[i].z;
      end
   end

   // stage 3: dot sums
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dot3_in[i] = DW'(prod2_ff[i].x) + DW'(prod2_ff[i].y) + DW'(prod2_ff[i].z);
      end
   end

   // stage 4: early exit test and partial products of the six cross terms
   always_comb begin
      e_w = E_W'(dot3_ff[0]) - E_W'(dot3_ff[1]) - E_W'(dot3_ff[2]);
      early4_in = e_w > $signed({2'b00, limit});
      part4_in[0] = split_mul(dot3_ff[3], dot3_ff[6]);
      part4_in[1] = split_mul(dot3_ff[5], dot3_ff[4]);
      part4_in[2] = split_mul(dot3_ff[7], dot3_ff[4]);
      part4_in[3] = split_mul(dot3_ff[3], dot3_ff[8]);
      part4_in[4] = split_mul(dot3_ff[5], dot3_ff[8]);
      part4_in[5] = split_mul(dot3_ff[7], dot3_ff[6]);
   end

   // stage 5: full products
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         prod5_in[i] = join_mul(part4_ff[i]);
      end
   end

   // stage 6: barycentric numerators
   always_comb begin
      vc6_in = NW'(prod5_ff[0]) - NW'(prod5_ff[1]);
      vb6_in = NW'(prod5_ff[2]) - NW'(prod5_ff[3]);
      va6_in = NW'(prod5_ff[4]) - NW'(prod5_ff[5]);
   end

   // stage 7: region tests in priority order
   always_comb begin
      n1 = NW'(d6_ff[0]);
      n2 = NW'(d6_ff[1]);
      n3 = NW'(d6_ff[2]);
      n4 = NW'(d6_ff[3]);
      n5 = NW'(d6_ff[4]);
      n6 = NW'(d6_ff[5]);
      d43 = n4 - n3;
      d56 = n5 - n6;
      den_f = va6_ff + vb6_ff + vc6_ff;
      task7_in.region = cpt_pkg::REG_FACE;
      task7_in.base   = geom6_ff.a;
      task7_in.e1     = geom6_ff.ab;
      task7_in.e2     = geom6_ff.ac;
      task7_in.num0   = '0;
      task7_in.num1   = '0;
      task7_in.den    = NW'(1);
      if (early6_ff) begin
         task7_in.region = cpt_pkg::REG_EARLY;
      end else if (nonpos(n1) && nonpos(n2)) begin
         task7_in.region = cpt_pkg::REG_VERT_A;
      end else if (!n3[NW-1] && (n4 <= n3)) begin
         task7_in.region = cpt_pkg::REG_VERT_B;
         task7_in.base   = geom6_ff.b;
      end else if (nonpos(vc6_ff) && !n1[NW-1] && nonpos(n3)) begin
         task7_in.region = cpt_pkg::REG_EDGE_AB;
         task7_in.num0   = n1;
         task7_in.den    = n1 - n3;
      end else if (!n6[NW-1] && (n5 <= n6)) begin
         task7_in.region = cpt_pkg::REG_VERT_C;
         task7_in.base   = geom6_ff.c;
      end else if (nonpos(vb6_ff) && !n2[NW-1] && nonpos(n6)) begin
         task7_in.region = cpt_pkg::REG_EDGE_AC;
         task7_in.e1     = geom6_ff.ac;
         task7_in.num0   = n2;
         task7_in.den    = n2 - n6;
      end else if (nonpos(va6_ff) && !d43[NW-1] && !d56[NW-1]) begin
         task7_in.region = cpt_pkg::REG_EDGE_BC;
         task7_in.base   = geom6_ff.b;
         task7_in.e1     = geom6_ff.cb;
         task7_in.num0   = d43;
         task7_in.den    = d43 + d56;
      end else if (nonpos(den_f)) begin
         // collinear corners
         task7_in.region = cpt_pkg::REG_VERT_A;
      end else begin
         task7_in.num0 = vb6_ff;
         task7_in.num1 = vc6_ff;
         task7_in.den  = den_f;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= a1_in;
         b1_ff  <= b1_in;
         c1_ff  <= c1_in;
         ap1_ff <= dsub(p1_w, a1_in);
         ab1_ff <= dsub(b1_in, a1_in);
         ac1_ff <= dsub(c1_in, a1_in);
         bp1_ff <= dsub(p1_w, b1_in);
         cp1_ff <= dsub(p1_w, c1_in);
         cb1_ff <= dsub(c1_in, b1_in);

         geom2_ff.a  <= a1_ff;
         geom2_ff.b  <= b1_ff;
         geom2_ff.c  <= c1_ff;
         geom2_ff.ab <= ab1_ff;
         geom2_ff.ac <= ac1_ff;
         geom2_ff.cb <= cb1_ff;
         geom3_ff <= geom2_ff;
         geom4_ff <= geom3_ff;
         geom5_ff <= geom4_ff;
         geom6_ff <= geom5_ff;

         for (int i = 0; i < 9; i++) begin
            prod2_ff[i] <= prod2_in[i];
            dot3_ff[i]  <= dot3_in[i];
         end
         early4_ff <= early4_in;
         early5_ff <= early4_ff;
         early6_ff <= early5_ff;
         for (int i = 0; i < 6; i++) begin
            d4_ff[i]    <= dot3_ff[i+3];
            d5_ff[i]    <= d4_ff[i];
            d6_ff[i]    <= d5_ff[i];
            part4_ff[i] <= part4_in[i];
            prod5_ff[i] <= prod5_in[i];
         end
         va6_ff   <= va6_in;
         vb6_ff   <= vb6_in;
         vc6_ff   <= vc6_in;
         task7_ff <= task7_in;
      end
   end

endmodule

// ===== hdl/cpt_queue.sv =====
// short queue of classified transactions between front and back
module cpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpt_pkg::task_type   push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output cpt_pkg::task_type   pop_data
);

   localparam int PTR_W = $clog2(cpt_pkg::QUEUE_DEPTH);

   cpt_pkg::task_type mem_ff [cpt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(cpt_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/cpt_back.sv =====
// back: fractions, weights, closest point and the output register
module cpt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  cpt_pkg::task_type   pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cpt_pkg::rsp_type    rsp_data
);

   localparam int LAT   = cpt_pkg::DIV_LAT;
   localparam int MUL_W = cpt_pkg::DIFF_W + cpt_pkg::FRAC_W;
   localparam int SUM_W = MUL_W + 2;
   localparam int POS_W = SUM_W - cpt_pkg::DIV_STEPS + 1;
   localparam int WW    = cpt_pkg::WEIGHT_W;

   typedef struct packed {
      cpt_pkg::region_type region;
      cpt_pkg::vec_type    base;
      cpt_pkg::dvec_type   e1;
      cpt_pkg::dvec_type   e2;
   } carry_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] x;
      logic signed [MUL_W-1:0] y;
      logic signed [MUL_W-1:0] z;
   } mvec_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } svec_type;

   typedef struct packed {
      logic [WW-1:0] a;
      logic [WW-1:0] b;
      logic [WW-1:0] c;
   } wts_type;

   function automatic logic signed [MUL_W-1:0] tmul(cpt_pkg::diff_type e,
                                                    logic [cpt_pkg::FRAC_W-1:0] t);
      return e * $signed({1'b0, t});
   endfunction

   function automatic logic [WW-1:0] to16(logic [cpt_pkg::FRAC_W-1:0] t);
      logic [cpt_pkg::FRAC_W:0] r;
      r = {1'b0, t} + (cpt_pkg::FRAC_W+1)'(32768);
      return WW'(r >> 16);
   endfunction

   function automatic logic signed [SUM_W-1:0] tsum(logic signed [MUL_W-1:0] p,
                                                    logic signed [MUL_W-1:0] q);
      return SUM_W'(p) + SUM_W'(q) + (SUM_W'(1) << (cpt_pkg::DIV_STEPS - 1));
   endfunction

   function automatic cpt_pkg::coord_type place(logic signed [SUM_W-1:0] s,
                                                cpt_pkg::coord_type b);
      logic signed [POS_W-1:0] x;
      x = POS_W'(s >>> cpt_pkg::DIV_STEPS) + POS_W'(b);
      if (x > POS_W'(cpt_pkg::COORD_MAX)) begin
         return cpt_pkg::COORD_MAX;
      end else if (x < POS_W'(cpt_pkg::COORD_MIN)) begin
         return cpt_pkg::COORD_MIN;
      end
      return cpt_pkg::COORD_W'(x);
   endfunction

   logic adv;
   logic [LAT-1:0] vld_ff;
   carry_type line_ff [LAT];
   carry_type line_in;
   logic [cpt_pkg::FRAC_W-1:0] t0, t1;
   logic [WW-1:0] s0, s1;
   logic [WW:0]   s01;

   logic mvld_ff, svld_ff, rsp_valid_ff;
   cpt_pkg::region_type mreg_ff, sreg_ff;
   cpt_pkg::vec_type    mbase_ff, sbase_ff;
   mvec_type mp1_ff, mp2_ff, mp1_in, mp2_in;
   svec_type sum_ff, sum_in;
   wts_type  mw_ff, mw_in, sw_ff;
   cpt_pkg::rsp_type rsp_ff, rsp_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = pop_valid && adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      line_in.region = pop_data.region;
      line_in.base   = pop_data.base;
      line_in.e1     = pop_data.e1;
      line_in.e2     = pop_data.e2;
   end

   cpt_div u_div0 (
      .clock (clock),
      .adv   (adv),
      .num   (pop_data.num0),
      .den   (pop_data.den),
      .frac  (t0)
   );

   cpt_div u_div1 (
      .clock (clock),
      .adv   (adv),
      .num   (pop_data.num1),
      .den   (pop_data.den),
      .frac  (t1)
   );

   // weights and edge products
   always_comb begin
      s0  = to16(t0);
      s1  = to16(t1);
      s01 = {1'b0, s0} + {1'b0, s1};
      mp1_in.x = tmul(line_ff[LAT-1].e1.x, t0);
      mp1_in.y = tmul(line_ff[LAT-1].e1.y, t0);
      mp1_in.z = tmul(line_ff[LAT-1].e1.z, t0);
      mp2_in.x = tmul(line_ff[LAT-1].e2.x, t1);
      mp2_in.y = tmul(line_ff[LAT-1].e2.y, t1);
      mp2_in.z = tmul(line_ff[LAT-1].e2.z, t1);
      mw_in.a = cpt_pkg::WEIGHT_ONE;
      mw_in.b = '0;
      mw_in.c = '0;
      unique case (line_ff[LAT-1].region)
         cpt_pkg::REG_EARLY, cpt_pkg::REG_VERT_A: begin
            mw_in.a = cpt_pkg::WEIGHT_ONE;
         end
         cpt_pkg::REG_VERT_B: begin
            mw_in.a = '0;
            mw_in.b = cpt_pkg::WEIGHT_ONE;
         end
         cpt_pkg::REG_VERT_C: begin
            mw_in.a = '0;
            mw_in.c = cpt_pkg::WEIGHT_ONE;
         end
         cpt_pkg::REG_EDGE_AB: begin
            mw_in.a = cpt_pkg::WEIGHT_ONE - s0;
            mw_in.b = s0;
         end
         cpt_pkg::REG_EDGE_AC: begin
            mw_in.a = cpt_pkg::WEIGHT_ONE - s0;
            mw_in.c = s0;
         end
         cpt_pkg::REG_EDGE_BC: begin
            mw_in.a = '0;
            mw_in.b = cpt_pkg::WEIGHT_ONE - s0;
            mw_in.c = s0;
         end
         cpt_pkg::REG_FACE: begin
            mw_in.a = (s01 >= {1'b0, cpt_pkg::WEIGHT_ONE}) ? '0 :
                      WW'({1'b0, cpt_pkg::WEIGHT_ONE} - s01);
            mw_in.b = s0;
            mw_in.c = s1;
         end
         default: begin
            mw_in.a = cpt_pkg::WEIGHT_ONE;
         end
      endcase
   end

   always_comb begin
      sum_in.x = tsum(mp1_ff.x, mp2_ff.x);
      sum_in.y = tsum(mp1_ff.y, mp2_ff.y);
      sum_in.z = tsum(mp1_ff.z, mp2_ff.z);
   end

   always_comb begin
      rsp_in.nearest_x = place(sum_ff.x, sbase_ff.x);
      rsp_in.nearest_y = place(sum_ff.y, sbase_ff.y);
      rsp_in.nearest_z = place(sum_ff.z, sbase_ff.z);
      rsp_in.weight_a  = sw_ff.a;
      rsp_in.weight_b  = sw_ff.b;
      rsp_in.weight_c  = sw_ff.c;
      rsp_in.region    = sreg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         mvld_ff      <= 1'b0;
         svld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-2:0], pop_valid};
         mvld_ff      <= vld_ff[LAT-1];
         svld_ff      <= mvld_ff;
         rsp_valid_ff <= svld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= line_in;
         for (int i = 1; i < LAT; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
         mreg_ff  <= line_ff[LAT-1].region;
         mbase_ff <= line_ff[LAT-1].base;
         mp1_ff   <= mp1_in;
         mp2_ff   <= mp2_in;
         mw_ff    <= mw_in;
         sreg_ff  <= mreg_ff;
         sbase_ff <= mbase_ff;
         sum_ff   <= sum_in;
         sw_ff    <= mw_ff;
         rsp_ff   <= rsp_in;
      end
   end

endmodule

// ===== hdl/closest_point_on_triangle_top.sv =====
// Closest point on a triangle to a query point: front, queue and back.
// Each req_ transaction carries a query point and three corners (signed Q8.16).
// Each rsp_ transaction returns the closest point, three Q1.16 barycentric
// weights and the region code; exactly one result per request, in order.
// csr_write_en / csr_write_data load the early exit limit (units 2^-32);
// write it only while no transaction is in flight. Reset loads all ones.
// Throughput: one transaction per cycle when nothing stalls. Path from
// acceptance to rsp_valid: 7 front stages, the queue, a 34-stage pipelined
// divider, a product stage, a sum stage and the output register.
// The divider, one quotient bit per stage, sets the latency.
// While rsp_valid and rsp_stall are high the back pipeline holds; the front
// keeps accepting until the four-entry queue fills, then raises req_stall.
// Reset is synchronous and empties all pipelines and the queue.
module closest_point_on_triangle_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cpt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cpt_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [cpt_pkg::LIMIT_W-1:0]   csr_write_data
);

   logic [cpt_pkg::LIMIT_W-1:0] limit_ff;
   logic              full, push, pop, pop_valid;
   cpt_pkg::task_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '1;
      end else if (csr_write_en) begin
         limit_ff <= csr_write_data;
      end
   end

   cpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .limit     (limit_ff),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   cpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   cpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/cpt_checker.sv =====
// checker for the closest point on triangle block: predicts and compares results
`timescale 1ns / 1ps
module cpt_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  cpt_pkg::req_type            req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  cpt_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_en,
   input  logic [cpt_pkg::LIMIT_W-1:0] csr_write_data,
   output int                          fail_count,
   output int                          pending,
   output int                          checked
);

   typedef logic signed [191:0] wide;

   localparam wide ONE16 = 65536;
   localparam wide ONE32 = wide'(1) <<< 32;

   cpt_pkg::rsp_type            nearest_queue[$];
   logic [cpt_pkg::LIMIT_W-1:0] exit_limit;

   function automatic wide dot3(input wide x[3], input wide y[3]);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
   endfunction

   // exact ratio saturated to [0,1], rounded half up to 32 fraction bits
   function automatic wide ratio32(input wide num, input wide den);
      wide q;
      wide rem;
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return ONE32;
      q = (num <<< 32) / den;
      rem = (num <<< 32) - q * den;
      if ((rem <<< 1) >= den) q = q + 1;
      return q;
   endfunction

   function automatic wide to_q16(input wide t);
      return (t + 32768) >>> 16;
   endfunction

   function automatic cpt_pkg::rsp_type build(input wide base[3], input wide e1[3],
                                              input wide t1, input wide e2[3], input wide t2,
                                              input wide wa, input wide wb, input wide wc,
                                              input cpt_pkg::region_type reg_code);
      cpt_pkg::rsp_type r;
      wide              s[3];
      for (int k = 0; k < 3; k++) begin
         s[k] = ((e1[k] * t1 + e2[k] * t2 + (wide'(1) <<< 31)) >>> 32) + base[k];
         if (s[k] > wide'(cpt_pkg::COORD_MAX)) s[k] = wide'(cpt_pkg::COORD_MAX);
         if (s[k] < wide'(cpt_pkg::COORD_MIN)) s[k] = wide'(cpt_pkg::COORD_MIN);
      end
      r.nearest_x = cpt_pkg::coord_type'(s[0]);
      r.nearest_y = cpt_pkg::coord_type'(s[1]);
      r.nearest_z = cpt_pkg::coord_type'(s[2]);
      r.weight_a  = cpt_pkg::WEIGHT_W'(wa);
      r.weight_b  = cpt_pkg::WEIGHT_W'(wb);
      r.weight_c  = cpt_pkg::WEIGHT_W'(wc);
      r.region    = reg_code;
      return r;
   endfunction

   function automatic cpt_pkg::rsp_type predict_result(input cpt_pkg::req_type q,
                                                       input logic [cpt_pkg::LIMIT_W-1:0] lim);
      wide pt[3], a[3], b[3], c[3], ap[3], ab[3], ac[3], bp[3], cp[3], cb[3];
      wide d1, d2, d3, d4, d5, d6, va, vb, vc, ex, den, t, v, w, vs, ws, wa;
      pt[0] = wide'(q.point_x);    pt[1] = wide'(q.point_y);    pt[2] = wide'(q.point_z);
      a[0]  = wide'(q.corner_a_x); a[1]  = wide'(q.corner_a_y); a[2]  = wide'(q.corner_a_z);
      b[0]  = wide'(q.corner_b_x); b[1]  = wide'(q.corner_b_y); b[2]  = wide'(q.corner_b_z);
      c[0]  = wide'(q.corner_c_x); c[1]  = wide'(q.corner_c_y); c[2]  = wide'(q.corner_c_z);
      for (int k = 0; k < 3; k++) begin
         ap[k] = pt[k] - a[k];
         ab[k] = b[k] - a[k];
         ac[k] = c[k] - a[k];
         bp[k] = pt[k] - b[k];
         cp[k] = pt[k] - c[k];
         cb[k] = c[k] - b[k];
      end
      ex = dot3(ap, ap) - dot3(ab, ab) - dot3(ac, ac);
      if (ex > wide'({1'b0, lim}))
         return build(a, ab, 0, ac, 0, ONE16, 0, 0, cpt_pkg::REG_EARLY);
      d1 = dot3(ab, ap);
      d2 = dot3(ac, ap);
      if (d1 <= 0 && d2 <= 0)
         return build(a, ab, 0, ac, 0, ONE16, 0, 0, cpt_pkg::REG_VERT_A);
      d3 = dot3(ab, bp);
      d4 = dot3(ac, bp);
      if (d3 >= 0 && d4 <= d3)
         return build(b, ab, 0, ac, 0, 0, ONE16, 0, cpt_pkg::REG_VERT_B);
      vc = d1 * d4 - d3 * d2;
      if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         t = ratio32(d1, d1 - d3);
         return build(a, ab, t, ac, 0, ONE16 - to_q16(t), to_q16(t), 0,
                      cpt_pkg::REG_EDGE_AB);
      end
      d5 = dot3(ab, cp);
      d6 = dot3(ac, cp);
      if (d6 >= 0 && d5 <= d6)
         return build(c, ab, 0, ac, 0, 0, 0, ONE16, cpt_pkg::REG_VERT_C);
      vb = d5 * d2 - d1 * d6;
      if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         t = ratio32(d2, d2 - d6);
         return build(a, ac, t, ab, 0, ONE16 - to_q16(t), 0, to_q16(t),
                      cpt_pkg::REG_EDGE_AC);
      end
      va = d3 * d6 - d5 * d4;
      if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
         t = ratio32(d4 - d3, (d4 - d3) + (d5 - d6));
         return build(b, cb, t, ab, 0, 0, ONE16 - to_q16(t), to_q16(t),
                      cpt_pkg::REG_EDGE_BC);
      end
      den = va + vb + vc;
      if (den <= 0)
         return build(a, ab, 0, ac, 0, ONE16, 0, 0, cpt_pkg::REG_VERT_A);
      v  = ratio32(vb, den);
      w  = ratio32(vc, den);
      vs = to_q16(v);
      ws = to_q16(w);
      wa = (vs + ws >= ONE16) ? 0 : ONE16 - vs - ws;
      return build(a, ab, v, ac, w, wa, vs, ws, cpt_pkg::REG_FACE);
   endfunction

   always @(posedge clock) begin
      cpt_pkg::rsp_type exp_r;
      if (reset) begin
         exit_limit = '1;
         nearest_queue.delete();
         fail_count = 0;
         checked    = 0;
      end else begin
         if (csr_write_en) exit_limit = csr_write_data;
         if (req_valid && !req_stall)
            nearest_queue.insert(nearest_queue.size(), predict_result(req_data, exit_limit));
         if (rsp_valid && !rsp_stall) begin
            if (nearest_queue.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               exp_r = nearest_queue.pop_front();
               checked++;
               if (rsp_data.nearest_x !== exp_r.nearest_x) begin
                  $error("nearest_x expected %0d got %0d", exp_r.nearest_x, rsp_data.nearest_x);
                  fail_count++;
               end
               if (rsp_data.nearest_y !== exp_r.nearest_y) begin
                  $error("nearest_y expected %0d got %0d", exp_r.nearest_y, rsp_data.nearest_y);
                  fail_count++;
               end
               if (rsp_data.nearest_z !== exp_r.nearest_z) begin
                  $error("nearest_z expected %0d got %0d", exp_r.nearest_z, rsp_data.nearest_z);
                  fail_count++;
               end
               if (rsp_data.weight_a !== exp_r.weight_a) begin
                  $error("weight_a expected %0d got %0d", exp_r.weight_a, rsp_data.weight_a);
                  fail_count++;
               end
               if (rsp_data.weight_b !== exp_r.weight_b) begin
                  $error("weight_b expected %0d got %0d", exp_r.weight_b, rsp_data.weight_b);
                  fail_count++;
               end
               if (rsp_data.weight_c !== exp_r.weight_c) begin
                  $error("weight_c expected %0d got %0d", exp_r.weight_c, rsp_data.weight_c);
                  fail_count++;
               end
               if (rsp_data.region !== exp_r.region) begin
                  $error("region expected %0d got %0d", exp_r.region, rsp_data.region);
                  fail_count++;
               end
            end
         end
      end
      pending = nearest_queue.size();
   end

endmodule

// ===== tb/tb_closest_point_on_triangle_top.sv =====
// testbench top: stimulus, idling and verdict for the closest point on triangle block
`timescale 1ns / 1ps
module tb_closest_point_on_triangle_top;

   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  ONE         = 65536;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   cpt_pkg::req_type            req_data;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   cpt_pkg::rsp_type            rsp_data;
   logic                        csr_write_en;
   logic [cpt_pkg::LIMIT_W-1:0] csr_write_data;
   int                          fail_count;
   int                          pending;
   int                          checked;
   int                          cycles = 0;
   int                          send_idle_pct;
   int                          recv_stall_pct;
   int                          hold_cycles = 0;
   int                          hold_request = 0;
   int                          hold_seen = 0;
   int                          sent;
   cpt_pkg::req_type            directed[$];

   closest_point_on_triangle_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   cpt_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen   <= hold_request;
         hold_cycles <= 300;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic cpt_pkg::req_type tri_item(input int px, py, pz, ax, ay, az,
                                                 input int bx, by, bz, cx, cy, cz);
      cpt_pkg::req_type r;
      r.point_x    = cpt_pkg::coord_type'(px); r.point_y    = cpt_pkg::coord_type'(py);
      r.point_z    = cpt_pkg::coord_type'(pz);
      r.corner_a_x = cpt_pkg::coord_type'(ax); r.corner_a_y = cpt_pkg::coord_type'(ay);
      r.corner_a_z = cpt_pkg::coord_type'(az);
      r.corner_b_x = cpt_pkg::coord_type'(bx); r.corner_b_y = cpt_pkg::coord_type'(by);
      r.corner_b_z = cpt_pkg::coord_type'(bz);
      r.corner_c_x = cpt_pkg::coord_type'(cx); r.corner_c_y = cpt_pkg::coord_type'(cy);
      r.corner_c_z = cpt_pkg::coord_type'(cz);
      return r;
   endfunction

   function automatic int near_coord(input int center, input int span);
      return center + int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic cpt_pkg::req_type random_item();
      cpt_pkg::req_type r;
      int      kind;
      int      span;
      int      ctr[3];
      int      v[12];
      kind = $urandom_range(99);
      span = ($urandom_range(3) == 0) ? 255 : (1 << $urandom_range(20, 10));
      for (int k = 0; k < 3; k++) ctr[k] = near_coord(0, 1 << 21);
      for (int i = 0; i < 12; i++) v[i] = near_coord(ctr[i % 3], span);
      if (kind < 20) begin
         r = cpt_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom});
         return r;
      end
      if (kind < 30) begin
         // coincident corners
         for (int k = 0; k < 3; k++) v[6 + k] = v[3 + k];
      end else if (kind < 38) begin
         // collinear corners: c = a + 2 (b - a)
         for (int k = 0; k < 3; k++) v[9 + k] = 2 * v[6 + k] - v[3 + k];
      end else if (kind < 42) begin
         for (int k = 0; k < 3; k++) begin
            v[6 + k] = v[3 + k];
            v[9 + k] = v[3 + k];
         end
      end
      return tri_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]);
   endfunction

   task automatic queue_item(input cpt_pkg::req_type r);
      directed.insert(directed.size(), r);
   endtask

   task automatic send_request(input cpt_pkg::req_type r);
      logic taken;
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
         if (taken) break;
      end
      sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_limit(input logic [cpt_pkg::LIMIT_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int                          ph;
      int                          idle_mix[4][2];
      logic [cpt_pkg::LIMIT_W-1:0] limits[5];
      idle_mix = '{'{0, 0}, '{73, 0}, '{0, 73}, '{21, 21}};
      limits   = '{'0, '1, cpt_pkg::LIMIT_W'(1) << 40, cpt_pkg::LIMIT_W'(1) << 33, '1};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sent           = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit right triangle scaled by 4 in the z = 0 plane
      queue_item(tri_item(-ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(6*ONE, -ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(2*ONE, -ONE, ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(-ONE, 6*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(-ONE, 3*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(3*ONE, 3*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(ONE, ONE, 2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(12345, 777, -3, 0, 0, 0, 3*ONE, 7, 0, 11, 5*ONE, 0));
      // degenerate edge, collinear corners, all corners equal
      queue_item(tri_item(3*ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 4*ONE, 0));
      queue_item(tri_item(ONE, ONE, 0, 0, 0, 0, 2*ONE, 0, 0, 4*ONE, 0, 0));
      queue_item(tri_item(ONE, ONE, ONE, 5, 5, 5, 5, 5, 5, 5, 5, 5));
      queue_item(tri_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // coordinate extremes, including saturation of the nearest point
      queue_item(cpt_pkg::req_type'({12{24'h7fffff}}));
      queue_item(cpt_pkg::req_type'({12{24'h800000}}));
      queue_item(tri_item(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                          8388607, -8388608, 8388607, -8388608, 8388607, 8388607));
      queue_item(tri_item(-8388608, 8388607, 0, 8388607, -8388608, -8388608,
                          -8388608, 8388607, 8388607, 8388607, 8388607, -8388608));
      queue_item(tri_item(8388607, 0, -8388608, 0, 0, 0, 8388607, 8388607, 0,
                          -8388608, 0, 8388607));
      foreach (directed[i]) send_request(directed[i]);
      drain();
      // early exit with the smallest limit
      write_limit('0);
      foreach (directed[i]) if (i < 8) send_request(directed[i]);
      drain();

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_mix[ph][0];
         recv_stall_pct = idle_mix[ph][1];
         write_limit(limits[ph] ^ ((ph == 2) ? cpt_pkg::LIMIT_W'($urandom) : '0));
         for (int i = 0; i < 340; i++) begin
            if (ph == 1 && i == 100) hold_request++;
            send_request(random_item());
         end
         drain();
      end
      write_limit(limits[4]);

      $display("sent %0d requests over four idle mixes and several early exit limits",
               sent);
      $display("%0d results checked, %0d failures", checked, fail_count);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
